/* sv/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg: shared types, constants and microcode for the scoreboard driver
// Holds the microprogram ROM, the segment table and the option bit positions.
// ----------------------------------------------------------------------------
`default_nettype none

package sbd_pkg;

    // Number of display groups and the width of a group index
    localparam int GROUPS = 16;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    localparam logic [9:0] MAX_VAL = 10'd999;

    // Option bits
    localparam int OPT_DASHES     = 0;
    localparam int OPT_DEC        = 1;
    localparam int OPT_DOT        = 2;
    localparam int OPT_ZERO_GREEN = 3;
    localparam int OPT_ZERO_RED   = 4;
    localparam int OPT_NOBLINK    = 5;
    localparam int OPT_NOBEEP     = 6;
    localparam int OPT_GREEN      = 7;

    localparam logic [7:0] SEG_DASH = 8'h08;
    localparam logic [7:0] DOT_BIT  = 8'h80;

    localparam logic [3:0] BLINK_RELOAD_RST = 4'd10;
    localparam logic [2:0] BEEP_RELOAD_RST  = 3'd4;

    typedef enum logic [0:0] {
        CFG_BLINK_RELOAD = 1'b0,
        CFG_BEEP_RELOAD  = 1'b1
    } cfg_idx_t;

    // Datapath operations, one per control word
    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,  // wait for an input beat and latch it
        OP_REFRESH = 3'd1,  // compare/store one group, arm counters
        OP_TICK    = 3'd2,  // beeper step, all blink counters step
        OP_LOAD    = 3'd3,  // fetch value and blink phase of current group
        OP_DIV     = 3'd4,  // hundreds digit and remainder
        OP_EMIT    = 3'd5,  // format and load the output register
        OP_NULL    = 3'd6   // load an all-zero, not-valid result
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_TICK      = 3'd2,
        COND_BAD_GROUP = 3'd3,
        COND_NO_BLINK  = 3'd4,
        COND_MORE      = 3'd5
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE     = 4'd0;
    localparam step_t STEP_REFRESH  = 4'd1;
    localparam step_t STEP_R_DIV    = 4'd2;
    localparam step_t STEP_R_EMIT   = 4'd3;
    localparam step_t STEP_TICK     = 4'd4;
    localparam step_t STEP_LOAD     = 4'd5;
    localparam step_t STEP_T_DIV    = 4'd6;
    localparam step_t STEP_T_EMIT   = 4'd7;
    localparam step_t STEP_T_RET    = 4'd8;
    localparam step_t STEP_NULL     = 4'd9;

    // One control word: operation, jump condition, jump target.
    // No jump means the next step in sequence.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Status from the datapath for jump decisions
    typedef struct packed {
        logic out_free;
        logic bad_group;
        logic any_blink;
        logic more;
    } dp_status_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            STEP_IDLE:    w = '{OP_IDLE,    COND_TICK,      STEP_TICK};
            STEP_REFRESH: w = '{OP_REFRESH, COND_BAD_GROUP, STEP_NULL};
            STEP_R_DIV:   w = '{OP_DIV,     COND_NEVER,     STEP_IDLE};
            STEP_R_EMIT:  w = '{OP_EMIT,    COND_ALWAYS,    STEP_IDLE};
            STEP_TICK:    w = '{OP_TICK,    COND_NO_BLINK,  STEP_NULL};
            STEP_LOAD:    w = '{OP_LOAD,    COND_NEVER,     STEP_IDLE};
            STEP_T_DIV:   w = '{OP_DIV,     COND_NEVER,     STEP_IDLE};
            STEP_T_EMIT:  w = '{OP_EMIT,    COND_MORE,      STEP_LOAD};
            STEP_T_RET:   w = '{OP_IDLE,    COND_ALWAYS,    STEP_IDLE};
            STEP_NULL:    w = '{OP_NULL,    COND_ALWAYS,    STEP_IDLE};
            default:      w = '{OP_IDLE,    COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

    // Seven-segment pattern of one decimal digit
    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h77;
            4'd1:    s = 8'h41;
            4'd2:    s = 8'h3B;
            4'd3:    s = 8'h6B;
            4'd4:    s = 8'h4D;
            4'd5:    s = 8'h6E;
            4'd6:    s = 8'h7E;
            4'd7:    s = 8'h43;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* sv/sbd_render.sv */
// ----------------------------------------------------------------------------
// sbd_render: segment formatter
// Splits the remainder into tens and ones and builds the three segment bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_render (
    input  wire logic [3:0] hund,      // hundreds digit
    input  wire logic [6:0] rem,       // value mod 100
    input  wire logic       num_zero,
    input  wire logic [7:0] opts,
    input  wire logic       refresh,   // refresh redraw (explicit zero bits apply)
    input  wire logic       grp_odd,
    input  wire logic       blank,
    output logic      [7:0] seg_ones,
    output logic      [7:0] seg_tens,
    output logic      [7:0] seg_hundreds
);

    logic [14:0] prod;
    logic [3:0]  tens_d;
    logic [3:0]  ones_d;
    logic [7:0]  dot;
    logic        zero_ok;

    // rem / 10 by reciprocal, exact for every 7-bit rem
    assign prod   = 15'(rem) * 15'd205;
    assign tens_d = prod[14:11];
    assign ones_d = 4'(rem - 7'(tens_d) * 7'd10);
    assign dot    = opts[sbd_pkg::OPT_DOT] ? sbd_pkg::DOT_BIT : 8'h00;
    assign zero_ok = grp_odd ? opts[sbd_pkg::OPT_ZERO_GREEN]
                             : opts[sbd_pkg::OPT_ZERO_RED];

    always_comb
    begin
        if (blank)
        begin
            seg_ones     = 8'h00;
            seg_tens     = 8'h00;
            seg_hundreds = 8'h00;
        end
        else if (num_zero && refresh && !zero_ok)
        begin
            seg_ones     = dot;
            seg_tens     = 8'h00;
            seg_hundreds = 8'h00;
        end
        else if (num_zero && opts[sbd_pkg::OPT_DASHES])
        begin
            seg_ones     = sbd_pkg::SEG_DASH | dot;
            seg_tens     = sbd_pkg::SEG_DASH;
            seg_hundreds = sbd_pkg::SEG_DASH;
        end
        else
        begin
            seg_ones     = sbd_pkg::digit_seg(ones_d) | dot;
            seg_tens     = (hund == 4'd0 && tens_d == 4'd0) ? 8'h00
                                                            : sbd_pkg::digit_seg(tens_d);
            seg_hundreds = (hund == 4'd0) ? 8'h00 : sbd_pkg::digit_seg(hund);
        end
    end

endmodule

`default_nettype wire

/* sv/sbd_sequencer.sv */
// ----------------------------------------------------------------------------
// sbd_sequencer: microprogram step counter
// Steps through the control ROM, holds on handshakes, takes conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_mode,
    input  wire sbd_pkg::dp_status_t status,
    output sbd_pkg::op_t             op,
    output logic                     in_ready
);

    sbd_pkg::step_t  step_reg;
    sbd_pkg::step_t  step_next;
    sbd_pkg::uword_t uw;
    logic            hold;
    logic            jump;

    assign uw = sbd_pkg::ucode(step_reg);
    assign op = uw.op;

    // Only the idle step takes an input beat
    assign in_ready = (step_reg == sbd_pkg::STEP_IDLE);

    always_comb
    begin
        case (uw.op)
            sbd_pkg::OP_IDLE: hold = !in_valid && (uw.cond == sbd_pkg::COND_TICK);
            sbd_pkg::OP_EMIT,
            sbd_pkg::OP_NULL: hold = !status.out_free;
            default:          hold = 1'b0;
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            sbd_pkg::COND_NEVER:     jump = 1'b0;
            sbd_pkg::COND_ALWAYS:    jump = 1'b1;
            sbd_pkg::COND_TICK:      jump = in_mode;
            sbd_pkg::COND_BAD_GROUP: jump = status.bad_group;
            sbd_pkg::COND_NO_BLINK:  jump = !status.any_blink;
            sbd_pkg::COND_MORE:      jump = status.more;
            default:                 jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
            step_next = step_reg;
        else if (jump)
            step_next = uw.target;
        else
            step_next = step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= sbd_pkg::STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

/* sv/sbd_datapath.sv */
// ----------------------------------------------------------------------------
// sbd_datapath: state, arithmetic and output register of the scoreboard
// Executes one microcode operation per cycle under control of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sbd_pkg::op_t        op,
    output sbd_pkg::dp_status_t      status,
    // input beat
    input  wire logic                in_valid,
    input  wire logic                in_mode,
    input  wire logic [3:0]          in_group,
    input  wire logic [9:0]          in_value,
    input  wire logic [7:0]          in_options,
    // register writes
    input  wire logic                cfg_we,
    input  wire sbd_pkg::cfg_idx_t   cfg_idx,
    input  wire logic [3:0]          cfg_wdata,
    // result beat
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [3:0]               out_group,
    output logic [7:0]               seg_ones,
    output logic [7:0]               seg_tens,
    output logic [7:0]               seg_hundreds,
    output logic                     group_valid,
    output logic                     beeper,
    output logic                     last
);

    localparam int GW = sbd_pkg::GRP_W;
    localparam int NG = sbd_pkg::GROUPS;
    localparam logic [GW-1:0] LAST_IDX = GW'(NG - 1);

    // Persistent state
    logic [9:0]    shown_reg [NG];
    logic [9:0]    shown_next [NG];
    logic [3:0]    blink_reg [NG];
    logic [3:0]    blink_next [NG];
    logic [2:0]    beep_cnt_reg, beep_cnt_next;
    logic          beeper_reg, beeper_next;
    logic [7:0]    opts_reg;
    logic [3:0]    blink_reload_reg;
    logic [2:0]    beep_reload_reg;

    // Working registers
    logic [3:0]    grp_reg;
    logic [9:0]    val_reg;
    logic          refresh_reg;
    logic [GW-1:0] idx_reg;
    logic [9:0]    num_reg;
    logic          blank_reg;
    logic [3:0]    hund_reg;
    logic [6:0]    rem_reg;

    // Output register
    logic          out_valid_reg;
    logic [3:0]    out_group_reg;
    logic [7:0]    ones_reg, tens_reg, hund_seg_reg;
    logic          gvalid_reg;
    logic          beep_out_reg;
    logic          last_reg;

    logic          out_free;
    logic          bad_group;
    logic          any_blink;
    logic [GW-1:0] rd_addr;
    logic [9:0]    rd_value;
    logic [9:0]    v_sat;
    logic          notify;
    logic [15:0]   div_prod;
    logic [3:0]    div_hund;
    logic [7:0]    r_ones, r_tens, r_hund;

    assign out_free  = !out_valid_reg || out_ready;
    assign bad_group = 32'(grp_reg) >= NG;

    always_comb
    begin
        any_blink = 1'b0;
        for (int i = 0; i < NG; i++)
            any_blink = any_blink | (blink_reg[i] != 4'd0);
    end

    assign status.out_free  = out_free;
    assign status.bad_group = bad_group;
    assign status.any_blink = any_blink;
    assign status.more      = idx_reg != LAST_IDX;

    // Single read port on the value store
    assign rd_addr  = (op == sbd_pkg::OP_REFRESH) ? GW'(grp_reg) : idx_reg;
    assign rd_value = shown_reg[rd_addr];

    assign v_sat  = (val_reg > sbd_pkg::MAX_VAL) ? sbd_pkg::MAX_VAL : val_reg;
    assign notify = (v_sat != rd_value)
                 && (!grp_reg[0] || opts_reg[sbd_pkg::OPT_GREEN])
                 && (opts_reg[sbd_pkg::OPT_DEC] || (v_sat > rd_value));

    // value / 100 by reciprocal, exact below 1000
    assign div_prod = 16'(num_reg) * 16'd41;
    assign div_hund = div_prod[15:12];

    sbd_render u_render (
        .hund         (hund_reg),
        .rem          (rem_reg),
        .num_zero     (num_reg == 10'd0),
        .opts         (opts_reg),
        .refresh      (refresh_reg),
        .grp_odd      (grp_reg[0]),
        .blank        (blank_reg),
        .seg_ones     (r_ones),
        .seg_tens     (r_tens),
        .seg_hundreds (r_hund)
    );

    // Store and counter updates
    always_comb
    begin
        shown_next    = shown_reg;
        blink_next    = blink_reg;
        beep_cnt_next = beep_cnt_reg;
        beeper_next   = beeper_reg;
        case (op)
            sbd_pkg::OP_REFRESH:
            begin
                if (!bad_group)
                begin
                    shown_next[rd_addr] = v_sat;
                    if (notify && !opts_reg[sbd_pkg::OPT_NOBLINK])
                        blink_next[rd_addr] = blink_reload_reg;
                    if (notify && !opts_reg[sbd_pkg::OPT_NOBEEP])
                        beep_cnt_next = beep_reload_reg;
                end
            end
            sbd_pkg::OP_TICK:
            begin
                if (beep_cnt_reg != 3'd0)
                begin
                    beeper_next   = !beep_cnt_reg[0];
                    beep_cnt_next = beep_cnt_reg - 3'd1;
                end
                for (int i = 0; i < NG; i++)
                    if (blink_reg[i] != 4'd0)
                        blink_next[i] = blink_reg[i] - 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NG; i++)
            begin
                shown_reg[i] <= 10'd0;
                blink_reg[i] <= 4'd0;
            end
            beep_cnt_reg     <= 3'd0;
            beeper_reg       <= 1'b0;
            opts_reg         <= 8'd0;
            blink_reload_reg <= sbd_pkg::BLINK_RELOAD_RST;
            beep_reload_reg  <= sbd_pkg::BEEP_RELOAD_RST;
            refresh_reg      <= 1'b0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            shown_reg    <= shown_next;
            blink_reg    <= blink_next;
            beep_cnt_reg <= beep_cnt_next;
            beeper_reg   <= beeper_next;

            if (cfg_we)
            begin
                case (cfg_idx)
                    sbd_pkg::CFG_BLINK_RELOAD: blink_reload_reg <= cfg_wdata;
                    sbd_pkg::CFG_BEEP_RELOAD:  beep_reload_reg  <= cfg_wdata[2:0];
                    default:
                    begin
                    end
                endcase
            end

            if (op == sbd_pkg::OP_IDLE && in_valid)
            begin
                refresh_reg <= !in_mode;
                if (!in_mode)
                    opts_reg <= in_options;
            end

            if (op == sbd_pkg::OP_TICK)
                idx_reg <= '0;
            else if (op == sbd_pkg::OP_EMIT && out_free && !refresh_reg)
                idx_reg <= idx_reg + GW'(1);

            if ((op == sbd_pkg::OP_EMIT || op == sbd_pkg::OP_NULL) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (op == sbd_pkg::OP_IDLE && in_valid)
        begin
            grp_reg <= in_group;
            val_reg <= in_value;
        end

        case (op)
            sbd_pkg::OP_REFRESH:
            begin
                num_reg   <= v_sat;
                blank_reg <= 1'b0;
            end
            sbd_pkg::OP_LOAD:
            begin
                num_reg   <= rd_value;
                blank_reg <= blink_reg[idx_reg][0];
            end
            sbd_pkg::OP_DIV:
            begin
                hund_reg <= div_hund;
                rem_reg  <= 7'(num_reg - 10'(div_hund) * 10'd100);
            end
            sbd_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    out_group_reg <= refresh_reg ? grp_reg : 4'(idx_reg);
                    ones_reg      <= r_ones;
                    tens_reg      <= r_tens;
                    hund_seg_reg  <= r_hund;
                    gvalid_reg    <= 1'b1;
                    beep_out_reg  <= beeper_reg;
                    last_reg      <= refresh_reg || (idx_reg == LAST_IDX);
                end
            end
            sbd_pkg::OP_NULL:
            begin
                if (out_free)
                begin
                    out_group_reg <= 4'd0;
                    ones_reg      <= 8'd0;
                    tens_reg      <= 8'd0;
                    hund_seg_reg  <= 8'd0;
                    gvalid_reg    <= 1'b0;
                    beep_out_reg  <= beeper_reg;
                    last_reg      <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_group    = out_group_reg;
    assign seg_ones     = ones_reg;
    assign seg_tens     = tens_reg;
    assign seg_hundreds = hund_seg_reg;
    assign group_valid  = gvalid_reg;
    // beeper level as of the beat, held with it while stalled
    assign beeper       = beep_out_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

/* sv/scoreboard_display_blink_beep.sv */
// ----------------------------------------------------------------------------
// scoreboard_display_blink_beep: seven-segment scoreboard driver
// Refreshes groups, runs blink and beep counters, emits segment bytes.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): one beat per item. s_tuser is the item kind:
//   0 refresh one group, 1 half-second tick. A refresh yields one result
//   beat; a tick yields one beat per group (tlast on the last group) while
//   any blink counter was running, else one not-valid beat (tuser 0).
//   Config port (cfg_*): always ready; index 0 blink reload, 1 beep reload.
//   Write it only while the block is idle.
//   Sequence: a refresh runs the refresh, divide and emit steps, then
//   returns to idle; its result loads into the output register at the
//   emit step. A tick with redraw runs one step for the counters, then
//   load, divide and format for each group, then one return step. A tick
//   without redraw runs the counter step and the null step. The steps come
//   from the microprogram, one control word per cycle unless held at idle or
//   at an emitting step, sharing one divide/format unit over all groups.
//   s_tready is high only while the sequencer sits at its idle step.
//   Stall: the output register holds its beat while m_tready is low; the
//   sequencer waits at the emitting step, the input side may still have
//   taken the item beforehand.
//   Reset: all group values and counters zero, beeper off, reloads 10 and 4.
// ----------------------------------------------------------------------------
`default_nettype none

module scoreboard_display_blink_beep (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // group[3:0], value[13:4], options[21:14], pad
    input  wire logic        s_tuser,   // mode
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_group[3:0], seg_ones[11:4], seg_tens[19:12],
                                        // seg_hundreds[27:20], beeper[28], pad
    output logic             m_tuser,   // group_valid
    output logic             m_tlast,   // last
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);

    sbd_pkg::op_t        op;
    sbd_pkg::dp_status_t status;
    logic                in_ready;
    logic [3:0]          out_group;
    logic [7:0]          seg_ones;
    logic [7:0]          seg_tens;
    logic [7:0]          seg_hundreds;
    logic                beeper;

    // Always able to take a register write
    assign cfg_ready = 1'b1;

    // Only the idle step takes an input beat
    assign s_tready  = in_ready;

    sbd_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tuser),
        .status   (status),
        .op       (op),
        .in_ready (in_ready)
    );

    sbd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .in_valid     (s_tvalid && s_tready),
        .in_mode      (s_tuser),
        .in_group     (s_tdata[3:0]),
        .in_value     (s_tdata[13:4]),
        .in_options   (s_tdata[21:14]),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (sbd_pkg::cfg_idx_t'(cfg_index)),
        .cfg_wdata    (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_group    (out_group),
        .seg_ones     (seg_ones),
        .seg_tens     (seg_tens),
        .seg_hundreds (seg_hundreds),
        .group_valid  (m_tuser),
        .beeper       (beeper),
        .last         (m_tlast)
    );

    assign m_tdata = {3'b000, beeper, seg_hundreds, seg_tens, seg_ones, out_group};

endmodule

`default_nettype wire

/* sv/sbd_checker.sv */
// ----------------------------------------------------------------------------
// sbd_checker: port-level checks for the scoreboard driver
// Watches the stream ports and flags ordering or framing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module sbd_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        m_tlast
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A not-valid result is a lone, all-blank beat
    a_null_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("not-valid result without tlast");

    a_null_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[27:0] == 28'd0)
        else $error("not-valid result carries segment data");

    // One item at a time: ready drops right after an accepted beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

endmodule

bind scoreboard_display_blink_beep sbd_checker u_sbd_checker (.*);

`default_nettype wire
